/* design/catch_handler_list_decoder_assert.svh */
// Assertion macros used by the decoder core module (chld_core).
// Each macro expects clk and rst to be visible where it is used.
`ifndef CATCH_HANDLER_LIST_DECODER_ASSERT_SVH
`define CATCH_HANDLER_LIST_DECODER_ASSERT_SVH

// Same-cycle implication.
`define CHLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("catch handler decoder: same-cycle check failed");

// Next-cycle implication.
`define CHLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("catch handler decoder: next-cycle check failed");

`endif

/* design/chld_pkg.sv */
package chld_pkg;

  // Longest LEB128 value accepted, in bytes
  localparam int unsigned LEB_MAX_BYTES = 5;
  localparam int unsigned CNT_W = $clog2(LEB_MAX_BYTES);

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_TYPE  = 4'b0100,
    PH_ADDR  = 4'b1000
  } phase_t;

  // Status codes
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_MALFORMED = 1'b1;

  // Outcome of adding one byte to a LEB128 value
  typedef struct packed {
    logic [31:0]      acc;
    logic [CNT_W-1:0] cnt;
    logic             done;
    logic             overlong;
    logic [31:0]      sval;
  } leb_res_t;

  // One emitted handler
  typedef struct packed {
    logic [31:0] type_index;
    logic [31:0] handler_address;
    logic        is_catch_all;
    logic        last;
    logic        status;
  } res_t;

endpackage

/* design/chld_leb.sv */
module chld_leb (
  input  logic [31:0]                 acc,
  input  logic [chld_pkg::CNT_W-1:0] cnt,
  input  logic [7:0]                  data,
  output chld_pkg::leb_res_t          leb
);

  logic [5:0]  sh;
  logic [5:0]  bits;
  logic [38:0] shifted;
  logic [31:0] acc_new;
  logic [chld_pkg::CNT_W-1:0] cnt_inc;

  // Place the 7-bit group at 7 times the byte position
  assign sh      = 6'(cnt) * 6'd7;
  assign bits    = sh + 6'd7;
  assign shifted = 39'(data[6:0]) << sh;
  assign acc_new = acc | shifted[31:0];
  assign cnt_inc = cnt + {{(chld_pkg::CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    leb.acc      = acc_new;
    leb.cnt      = cnt_inc;
    leb.done     = ~data[7];
    leb.overlong = data[7] && (32'(cnt_inc) >= chld_pkg::LEB_MAX_BYTES);
    // Sign extension from bit 6 of the final byte
    if (bits < 6'd32 && data[6]) begin
      leb.sval = acc_new | (chld_pkg::ALL_ONES << bits);
    end else begin
      leb.sval = acc_new;
    end
  end

endmodule

/* design/chld_core.sv */
`include "catch_handler_list_decoder_assert.svh"

module chld_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             start_req,
  input  logic [7:0]       data_byte,
  output logic             res_valid,
  output chld_pkg::res_t   res
);

  chld_pkg::phase_t phase, phase_next, eff_phase;
  logic [31:0] acc, acc_next, eff_acc;
  logic [chld_pkg::CNT_W-1:0] cnt, cnt_next, eff_cnt;
  logic [31:0] pairs, pairs_next, eff_pairs, pairs_dec;
  logic catch_all, catch_all_next, eff_catch;
  logic [31:0] pending, pending_next, eff_pending;
  logic [31:0] cnt_val;
  chld_pkg::leb_res_t leb;

  // A start byte begins from a fresh list
  always_comb begin
    eff_phase   = start_req ? chld_pkg::PH_COUNT : phase;
    eff_acc     = start_req ? '0 : acc;
    eff_cnt     = start_req ? '0 : cnt;
    eff_pairs   = start_req ? '0 : pairs;
    eff_catch   = start_req ? 1'b0 : catch_all;
    eff_pending = start_req ? '0 : pending;
  end

  chld_leb u_leb (
    .acc  (eff_acc),
    .cnt  (eff_cnt),
    .data (data_byte),
    .leb  (leb)
  );

  assign cnt_val   = leb.sval;
  assign pairs_dec = eff_pairs - 32'd1;

  // Phase machine and result formation
  always_comb begin
    phase_next     = eff_phase;
    acc_next       = eff_acc;
    cnt_next       = eff_cnt;
    pairs_next     = eff_pairs;
    catch_all_next = eff_catch;
    pending_next   = eff_pending;
    res_valid      = 1'b0;
    res            = '0;
    if (step && eff_phase != chld_pkg::PH_IDLE) begin
      if (leb.overlong) begin
        phase_next     = chld_pkg::PH_IDLE;
        acc_next       = '0;
        cnt_next       = '0;
        pairs_next     = '0;
        catch_all_next = 1'b0;
        res_valid      = 1'b1;
        res.last       = 1'b1;
        res.status     = chld_pkg::ST_MALFORMED;
      end else if (!leb.done) begin
        acc_next = leb.acc;
        cnt_next = leb.cnt;
      end else begin
        acc_next = '0;
        cnt_next = '0;
        case (eff_phase)
          chld_pkg::PH_COUNT: begin
            // zero or negative count: catch-everything list
            if (cnt_val == 32'd0 || cnt_val[31]) begin
              catch_all_next = 1'b1;
              pairs_next     = 32'd0 - cnt_val;
            end else begin
              catch_all_next = 1'b0;
              pairs_next     = cnt_val;
            end
            if (pairs_next != 32'd0) begin
              phase_next = chld_pkg::PH_TYPE;
            end else begin
              pending_next = chld_pkg::ALL_ONES;
              phase_next   = chld_pkg::PH_ADDR;
            end
          end
          chld_pkg::PH_TYPE: begin
            pending_next = leb.acc;
            phase_next   = chld_pkg::PH_ADDR;
          end
          chld_pkg::PH_ADDR: begin
            res_valid           = 1'b1;
            res.handler_address = leb.acc;
            res.status          = chld_pkg::ST_OK;
            if (eff_pairs != 32'd0) begin
              pairs_next     = pairs_dec;
              res.type_index = eff_pending;
              if (pairs_dec != 32'd0) begin
                phase_next = chld_pkg::PH_TYPE;
              end else if (eff_catch) begin
                phase_next   = chld_pkg::PH_ADDR;
                pending_next = chld_pkg::ALL_ONES;
              end else begin
                phase_next = chld_pkg::PH_IDLE;
                res.last   = 1'b1;
              end
            end else begin
              catch_all_next   = 1'b0;
              phase_next       = chld_pkg::PH_IDLE;
              res.type_index   = chld_pkg::ALL_ONES;
              res.is_catch_all = 1'b1;
              res.last         = 1'b1;
            end
          end
          default: begin
            phase_next = chld_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= chld_pkg::PH_IDLE;
      acc       <= '0;
      cnt       <= '0;
      pairs     <= '0;
      catch_all <= 1'b0;
      pending   <= '0;
    end else if (step) begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      pairs     <= pairs_next;
      catch_all <= catch_all_next;
      pending   <= pending_next;
    end
  end

  `CHLD_ASSERT_NOW(a_res_needs_step, res_valid, step)
  `CHLD_ASSERT_NOW(a_bad_is_last, res_valid && res.status, res.last && !res.is_catch_all)
  `CHLD_ASSERT_NOW(a_catch_all_entry, res_valid && res.is_catch_all,
                   res.last && res.type_index == chld_pkg::ALL_ONES)
  `CHLD_ASSERT_NEXT(a_idle_holds, step && !start_req && phase == chld_pkg::PH_IDLE,
                    phase == chld_pkg::PH_IDLE)
  `CHLD_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt) < chld_pkg::LEB_MAX_BYTES)

endmodule

/* design/catch_handler_list_decoder.sv */
// Catch handler list decoder.
// Input channel (in_valid / in_stall, start_req, data_byte): one byte of an
// encoded exception handler list per transaction; start_req marks the first
// byte of a list and abandons any list in progress.
// Output channel (out_valid / out_stall): one transaction per completed
// handler with type_index, handler_address, is_catch_all, last and status.
// A malformed (overlong) LEB128 value gives one transaction with status set
// and last set, after which bytes are ignored until the next start.
// Throughput: one byte per cycle when not stalled; each byte passes an input
// register, one phase machine and LEB128 step, then the result register.
// Result: a result is offered once its closing byte has been accepted, at the
// edge where that byte leaves the input register for the result register.
// Stall: while the result register holds an untaken result under out_stall,
// at most one more byte is taken into the input register, then in_stall rises.
// Reset (rst, synchronous): clears both registers' valid flags and returns
// the decoder to idle with an empty accumulator; no handler is pending.
module catch_handler_list_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] type_index,
  output logic [31:0] handler_address,
  output logic        is_catch_all,
  output logic        last,
  output logic        status
);

  logic           s1_valid;
  logic           s1_start;
  logic [7:0]     s1_byte;
  logic           adv;
  logic           accept;
  logic           res_valid;
  chld_pkg::res_t res;
  chld_pkg::res_t out_res;

  // Advance when the result register is free or being emptied
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= start_req;
      s1_byte  <= data_byte;
    end
  end

  chld_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .start_req (s1_start),
    .data_byte (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

  assign type_index      = out_res.type_index;
  assign handler_address = out_res.handler_address;
  assign is_catch_all    = out_res.is_catch_all;
  assign last            = out_res.last;
  assign status          = out_res.status;

endmodule
